// ===== rtl/core/lfb_pkg.sv =====
// ----------------------------------------------------------------------------
// lfb_pkg
// Shared types and constants of the LED fade and blink controller.
// ----------------------------------------------------------------------------
package lfb_pkg;

    localparam int unsigned TIME_W  = 16;  // millisecond counters and periods
    localparam int unsigned LEVEL_W = 8;   // brightness values

    // Kind of word on the input channel.
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_FADE  = 2'd1,
        REQ_BLINK = 2'd2,
        REQ_SET   = 2'd3
    } t_req;

    // Operating mode; the fourth code is never stored.
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_FADE  = 2'd1,
        MODE_BLINK = 2'd2
    } t_mode;

    // Serial divider control.
    typedef enum logic {
        DIV_IDLE = 1'b0,
        DIV_RUN  = 1'b1
    } t_div_state;

endpackage

// ===== rtl/core/lfb_div.sv =====
// ----------------------------------------------------------------------------
// lfb_div
// Bit-serial restoring divider: one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module lfb_div
    import lfb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [TIME_W-1:0]  i_dividend,
    input  logic [LEVEL_W-1:0] i_divisor,
    output logic               o_busy,
    output logic               o_done,
    output logic [TIME_W-1:0]  o_quotient
);

    localparam int unsigned CNT_W = $clog2(TIME_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(TIME_W - 1);

    t_div_state r_state;
    t_div_state n_state;

    logic [CNT_W-1:0]   r_count;
    logic [TIME_W-1:0]  r_quo;     // dividend bits shift out, quotient bits shift in
    logic [LEVEL_W-1:0] r_rem;
    logic [LEVEL_W-1:0] r_divisor;

    logic [LEVEL_W:0]   trial;
    logic [LEVEL_W:0]   trial_diff;
    logic               q_bit;
    logic [LEVEL_W-1:0] rem_next;
    logic               last_step;

    // One restoring step on the partial remainder.
    always_comb begin
        trial      = {r_rem, r_quo[TIME_W-1]};
        trial_diff = trial - {1'b0, r_divisor};
        q_bit      = (trial >= {1'b0, r_divisor});
        rem_next   = q_bit ? trial_diff[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
        last_step  = (r_count == LAST_BIT);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            DIV_IDLE: begin
                if (i_start) begin
                    n_state = DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (last_step) begin
                    n_state = DIV_IDLE;
                end
            end
            default: n_state = DIV_IDLE;
        endcase
    end

    always_comb begin
        o_busy     = (r_state == DIV_RUN);
        o_done     = (r_state == DIV_RUN) && last_step;
        o_quotient = {r_quo[TIME_W-2:0], q_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == DIV_RUN) begin
                r_count <= r_count + CNT_W'(1);
            end else begin
                r_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == DIV_IDLE && i_start) begin
            r_quo     <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_state == DIV_RUN) begin
            r_quo <= {r_quo[TIME_W-2:0], q_bit};
            r_rem <= rem_next;
        end
    end

endmodule

// ===== rtl/core/led_fade_blink_controller.sv =====
// ----------------------------------------------------------------------------
// led_fade_blink_controller
// LED brightness sequencer driven by command words and millisecond ticks.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid / o_in_stall) takes one word per item: a
//   millisecond tick, a fade command, a blink command or a set command. The
//   output channel (o_out_valid / i_out_stall) returns exactly one word per
//   accepted item: brightness, a changed flag and the mode after that item.
//   Every item has its result in the output register in the cycle after it is
//   accepted. Ticks, blink and set commands, and fade commands to the
//   current level, are taken one item per cycle while the receiver keeps
//   up. A fade command whose target differs from the current brightness
//   starts the bit-serial divider, which works out the step period one
//   quotient bit per cycle; the input stalls while the divider runs.
//   When the receiver stalls, the result stays in the output register and a
//   new word is taken only in a cycle in which the waiting one leaves.
//   Reset clears the mode to idle, all levels, times and counters to zero,
//   and empties the output register.
// ----------------------------------------------------------------------------
module led_fade_blink_controller
    import lfb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel.
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [TIME_W-1:0]  i_fade_duration,
    input  logic [LEVEL_W-1:0] i_fade_target,
    input  logic [TIME_W-1:0]  i_low_time,
    input  logic [TIME_W-1:0]  i_high_time,
    input  logic [LEVEL_W-1:0] i_low_level,
    input  logic [LEVEL_W-1:0] i_high_level,
    input  logic [LEVEL_W-1:0] i_direct_level,
    // Output channel.
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [LEVEL_W-1:0] o_brightness,
    output logic               o_changed,
    output logic [1:0]         o_mode_now
);

    // Sequencer state.
    t_mode              r_mode;
    logic [LEVEL_W-1:0] r_level;
    logic [TIME_W-1:0]  r_elapsed;
    logic [TIME_W-1:0]  r_step_period;
    logic [LEVEL_W-1:0] r_target;
    logic [TIME_W-1:0]  r_blink_low_time;
    logic [TIME_W-1:0]  r_blink_high_time;
    logic [LEVEL_W-1:0] r_blink_low_level;
    logic [LEVEL_W-1:0] r_blink_high_level;
    logic               r_phase_high;

    t_mode              n_mode;
    logic [LEVEL_W-1:0] n_level;
    logic [TIME_W-1:0]  n_elapsed;
    logic [TIME_W-1:0]  n_step_period;
    logic [LEVEL_W-1:0] n_target;
    logic [TIME_W-1:0]  n_blink_low_time;
    logic [TIME_W-1:0]  n_blink_high_time;
    logic [LEVEL_W-1:0] n_blink_low_level;
    logic [LEVEL_W-1:0] n_blink_high_level;
    logic               n_phase_high;
    logic               n_changed;

    // Output register.
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_brightness;
    logic               r_changed;
    t_mode              r_mode_now;

    logic               in_accept;
    logic               out_take;
    t_req               req;
    logic [LEVEL_W-1:0] fade_diff;
    logic [TIME_W-1:0]  tick_count;
    logic [TIME_W-1:0]  blink_limit;

    logic               div_start;
    logic               div_busy;
    logic               div_done;
    logic [TIME_W-1:0]  div_quotient;

    lfb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_fade_duration),
        .i_divisor  (fade_diff),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // The input waits while the divider runs, and while a result is held by
    // the receiver. A result that leaves this cycle frees the register.
    assign out_take   = r_out_valid && !i_out_stall;
    assign o_in_stall = div_busy || (r_out_valid && i_out_stall);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign req        = t_req'(i_req_type);
    assign fade_diff  = (i_fade_target >= r_level) ? (i_fade_target - r_level)
                                                   : (r_level - i_fade_target);
    assign tick_count = r_elapsed + TIME_W'(1);
    assign blink_limit = r_phase_high ? r_blink_high_time : r_blink_low_time;

    always_comb begin
        n_mode             = r_mode;
        n_level            = r_level;
        n_elapsed          = r_elapsed;
        n_step_period      = r_step_period;
        n_target           = r_target;
        n_blink_low_time   = r_blink_low_time;
        n_blink_high_time  = r_blink_high_time;
        n_blink_low_level  = r_blink_low_level;
        n_blink_high_level = r_blink_high_level;
        n_phase_high       = r_phase_high;
        n_changed          = 1'b0;
        div_start          = 1'b0;

        // The quotient lands while the input is stalled, so it never meets
        // an accepted word in the same cycle.
        if (div_done) begin
            n_step_period = div_quotient;
        end

        if (in_accept) begin
            case (req)
                REQ_TICK: begin
                    // The counter advances in every mode and clears only
                    // when a step fires.
                    n_elapsed = tick_count;
                    case (r_mode)
                        MODE_FADE: begin
                            if (tick_count >= r_step_period) begin
                                n_elapsed = '0;
                                n_changed = 1'b1;
                                if (r_level == r_target) begin
                                    n_mode = MODE_IDLE;
                                end else if (r_level > r_target) begin
                                    n_level = r_level - LEVEL_W'(1);
                                end else begin
                                    n_level = r_level + LEVEL_W'(1);
                                end
                            end
                        end
                        MODE_BLINK: begin
                            if (tick_count >= blink_limit) begin
                                n_elapsed    = '0;
                                n_changed    = 1'b1;
                                n_level      = r_phase_high ? r_blink_low_level
                                                            : r_blink_high_level;
                                n_phase_high = !r_phase_high;
                            end
                        end
                        default: ;
                    endcase
                end
                REQ_FADE: begin
                    // A fade to the current level gets a period of zero;
                    // otherwise the divider supplies duration / difference.
                    n_target = i_fade_target;
                    n_mode   = MODE_FADE;
                    if (fade_diff == '0) begin
                        n_step_period = '0;
                    end else begin
                        div_start = 1'b1;
                    end
                end
                REQ_BLINK: begin
                    n_blink_low_time   = i_low_time;
                    n_blink_high_time  = i_high_time;
                    n_blink_low_level  = i_low_level;
                    n_blink_high_level = i_high_level;
                    n_phase_high       = 1'b0;
                    n_mode             = MODE_BLINK;
                end
                REQ_SET: begin
                    n_level   = i_direct_level;
                    n_changed = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode             <= MODE_IDLE;
            r_level            <= '0;
            r_elapsed          <= '0;
            r_step_period      <= '0;
            r_target           <= '0;
            r_blink_low_time   <= '0;
            r_blink_high_time  <= '0;
            r_blink_low_level  <= '0;
            r_blink_high_level <= '0;
            r_phase_high       <= 1'b0;
            r_out_valid        <= 1'b0;
        end else begin
            r_mode             <= n_mode;
            r_level            <= n_level;
            r_elapsed          <= n_elapsed;
            r_step_period      <= n_step_period;
            r_target           <= n_target;
            r_blink_low_time   <= n_blink_low_time;
            r_blink_high_time  <= n_blink_high_time;
            r_blink_low_level  <= n_blink_low_level;
            r_blink_high_level <= n_blink_high_level;
            r_phase_high       <= n_phase_high;
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The result of every word is known in its accept cycle.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_brightness <= n_level;
            r_changed    <= n_changed;
            r_mode_now   <= n_mode;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_brightness = r_brightness;
    assign o_changed    = r_changed;
    assign o_mode_now   = r_mode_now;

endmodule

// ===== rtl/core/lfb_checker.sv =====
// ----------------------------------------------------------------------------
// lfb_checker
// Port-level checks of the LED fade and blink controller, bound to the top.
// ----------------------------------------------------------------------------
module lfb_checker
    import lfb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [LEVEL_W-1:0] i_direct_level,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  logic [LEVEL_W-1:0] o_brightness,
    input  logic               o_changed,
    input  logic [1:0]         o_mode_now
);

    logic in_accept;
    assign in_accept = i_in_valid && !o_in_stall;

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    // A held result does not change while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_brightness) && $stable(o_changed)
            && $stable(o_mode_now))
        else $error("stalled output word changed");

    // A set command's result word shows its level and reports a change.
    a_set_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (i_req_type == REQ_SET) |=>
            o_out_valid && o_changed && (o_brightness == $past(i_direct_level)))
        else $error("set command result wrong");

    // Fade and blink commands switch mode without reporting a change.
    a_cmd_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && ((i_req_type == REQ_FADE) || (i_req_type == REQ_BLINK)) |=>
            o_out_valid && !o_changed && (o_mode_now == $past(i_req_type)))
        else $error("command result mode or change flag wrong");

    // The unused mode code never reaches the output.
    a_mode_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_mode_now != 2'd3))
        else $error("unused mode code on output");

endmodule

bind led_fade_blink_controller lfb_checker u_lfb_checker (.*);
